/* sv/murmur3_32_stream_hash_assert.svh */
// assertion macros for the murmur3 stream hash block
// expects clk and rst_n in the scope of every use
`ifndef MURMUR3_32_STREAM_HASH_ASSERT_SVH
`define MURMUR3_32_STREAM_HASH_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define MM3_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define MM3_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MM3_ASSERT_IMP(lbl, ante, cons, msg)
`define MM3_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

/* sv/mm3_pkg.sv */
// shared types, constants and helper functions for the murmur3 stream hash
// no dependencies
package mm3_pkg;

    localparam int unsigned WORD_W = 32;

    typedef logic [WORD_W-1:0] word_t;

    localparam word_t MM_C1 = 32'hCC9E_2D51;
    localparam word_t MM_C2 = 32'h1B87_3593;
    localparam word_t MM_N  = 32'hE654_6B64;
    localparam word_t MM_F1 = 32'h85EB_CA6B;
    localparam word_t MM_F2 = 32'hC2B2_AE35;

    localparam logic [2:0] FULL_COUNT = 3'd4;

    // sequencer states, one-hot
    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_K1   = 7'b0000010,
        ST_K2   = 7'b0000100,
        ST_K3   = 7'b0001000,
        ST_F1   = 7'b0010000,
        ST_F2   = 7'b0100000,
        ST_F3   = 7'b1000000
    } state_t;

    function automatic word_t rotl15(input word_t v);
        return {v[16:0], v[31:17]};
    endfunction

    function automatic word_t rotl13(input word_t v);
        return {v[18:0], v[31:19]};
    endfunction

    // keep only the low valid bytes of a word
    function automatic word_t byte_mask(input logic [2:0] cnt);
        word_t m;
        case (cnt)
            3'd0:    m = 32'h0000_0000;
            3'd1:    m = 32'h0000_00FF;
            3'd2:    m = 32'h0000_FFFF;
            3'd3:    m = 32'h00FF_FFFF;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

/* sv/murmur3_32_stream_hash.sv */
// top level of the murmur3 x86_32 stream hash: sequencer, hash state, output register
// depends on mm3_pkg, mm3_mul and murmur3_32_stream_hash_assert.svh
//
// channel   dir  fields (lowest bit up)                      handshake
// s_*       in   tdata: data_word[31:0], byte_count[34:32]   tvalid/tready
//                tlast: last
// m_*       out  tdata: hash[31:0]                           tvalid/tready
// cfg_*     in   cfg_wdata: seed                             cfg_we, no wait
//
// a full word is accepted in idle and then runs three steps, K1, K2 and K3:
// the first two use one registered 32x32 multiplier (c1, then c2), the
// third mixes the product into the running hash
// a last item adds finalization steps F1, F2, F3, the first two of which use
// the same multiplier (f1, f2); a zero-count item that is not last stays in idle
// the final step waits while the output register still holds an untaken hash;
// one finished hash may wait on the master side while the next message runs
// reset clears the sequencer, the running length, the start flag and the output valid, and sets the seed to all ones
`include "murmur3_32_stream_hash_assert.svh"

module murmur3_32_stream_hash
    import mm3_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // slave side
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // data_word[31:0], byte_count[34:32], zero pad
    input  logic        s_tlast,   // last
    // master side
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // hash[31:0]
    // seed register
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata
);

    state_t     state_reg, state_next;
    word_t      seed_reg;
    word_t      h_reg, h_next;         // running hash
    word_t      len_reg, len_next;     // running byte length, mod 2^32
    logic       started_reg, started_next;
    word_t      k_reg, k_next;         // masked input word
    logic       full_reg, full_next;   // word had four bytes
    logic       last_reg, last_next;
    word_t      hash_reg, hash_next;
    logic       out_valid_reg, out_valid_next;

    // shared multiplier
    logic       mul_en;
    word_t      mul_a, mul_b, mul_p;

    // input unpacking
    word_t      in_word;
    logic [2:0] in_cnt_raw, in_cnt;
    logic       in_accept;

    word_t      h_base;
    word_t      h_mixed;
    word_t      h_rot;
    word_t      fin_pre;
    word_t      fin_mid;
    word_t      fin_out;
    logic       out_free;

    assign in_word    = s_tdata[31:0];
    assign in_cnt_raw = s_tdata[34:32];
    // counts above four are treated as four
    assign in_cnt     = (in_cnt_raw > FULL_COUNT) ? FULL_COUNT : in_cnt_raw;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = hash_reg;

    // output register can take a new hash this cycle
    assign out_free = !out_valid_reg || m_tready;

    // first item of a message starts from the seed
    assign h_base = started_reg ? h_reg : seed_reg;

    // block mix: xor the scrambled word, full words also rotate, multiply by 5 and add n
    assign h_rot   = rotl13(h_reg ^ mul_p);
    assign h_mixed = full_reg ? ((h_rot << 2) + h_rot + MM_N) : (h_reg ^ mul_p);

    // finalization pieces around the two multiplies
    assign fin_pre = (h_reg ^ len_reg) ^ ((h_reg ^ len_reg) >> 16);
    assign fin_mid = mul_p ^ (mul_p >> 13);
    assign fin_out = mul_p ^ (mul_p >> 16);

    // multiplier operand select
    always_comb
    begin
        mul_en = 1'b0;
        mul_a  = k_reg;
        mul_b  = MM_C1;
        case (state_reg)
            ST_K1:
            begin
                mul_en = 1'b1;
                mul_a  = k_reg;
                mul_b  = MM_C1;
            end
            ST_K2:
            begin
                mul_en = 1'b1;
                mul_a  = rotl15(mul_p);
                mul_b  = MM_C2;
            end
            ST_F1:
            begin
                mul_en = 1'b1;
                mul_a  = fin_pre;
                mul_b  = MM_F1;
            end
            ST_F2:
            begin
                mul_en = 1'b1;
                mul_a  = fin_mid;
                mul_b  = MM_F2;
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    mm3_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_p)
    );

    // sequencer and hash state
    always_comb
    begin
        state_next     = state_reg;
        h_next         = h_reg;
        len_next       = len_reg;
        started_next   = started_reg;
        k_next         = k_reg;
        full_next      = full_reg;
        last_next      = last_reg;
        hash_next      = hash_reg;
        out_valid_next = out_valid_reg && !m_tready;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    h_next       = h_base;
                    started_next = 1'b1;
                    len_next     = len_reg + {29'd0, in_cnt};
                    k_next       = in_word & byte_mask(in_cnt);
                    full_next    = (in_cnt == FULL_COUNT);
                    last_next    = s_tlast;
                    if (in_cnt != 3'd0)
                    begin
                        state_next = ST_K1;
                    end
                    else if (s_tlast)
                    begin
                        state_next = ST_F1;
                    end
                end
            end
            ST_K1:
            begin
                state_next = ST_K2;
            end
            ST_K2:
            begin
                state_next = ST_K3;
            end
            ST_K3:
            begin
                h_next     = h_mixed;
                state_next = last_reg ? ST_F1 : ST_IDLE;
            end
            ST_F1:
            begin
                state_next = ST_F2;
            end
            ST_F2:
            begin
                state_next = ST_F3;
            end
            ST_F3:
            begin
                // hold until the previous hash has left
                if (out_free)
                begin
                    hash_next      = fin_out;
                    out_valid_next = 1'b1;
                    len_next       = '0;
                    started_next   = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= '0;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            seed_reg      <= 32'hFFFF_FFFF;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            started_reg   <= started_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                seed_reg <= cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        h_reg    <= h_next;
        k_reg    <= k_next;
        full_reg <= full_next;
        last_reg <= last_next;
        hash_reg <= hash_next;
    end

    // a new hash only appears out of the final step
    `MM3_ASSERT_IMP(a_hash_from_final, $rose(m_tvalid), $past(state_reg == ST_F3), "hash without final step")
    // finishing a message clears length and start flag
    `MM3_ASSERT_IMP(a_state_cleared, $rose(m_tvalid), (len_reg == '0) && !started_reg, "message state not cleared")
    // a last transaction always leads into finalization
    `MM3_ASSERT_NXT(a_last_busy, s_tvalid && s_tready && s_tlast, !s_tready, "last transaction did not finalize")

endmodule

/* sv/mm3_mul.sv */
// shared 32x32 multiplier, low half of the product, registered output
// depends on mm3_pkg
module mm3_mul
    import mm3_pkg::*;
(
    input  logic  clk,
    input  logic  en,
    input  word_t a,
    input  word_t b,
    output word_t prod
);

    word_t prod_reg;
    word_t prod_next;

    assign prod_next = a * b;

    // payload only, holds while not enabled
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule
